// ----- src/dominant_label_nearest_point_gate_macros.svh -----
// assertion macros for the dominant label gate
`ifndef DOMINANT_LABEL_NEAREST_POINT_GATE_MACROS_SVH
`define DOMINANT_LABEL_NEAREST_POINT_GATE_MACROS_SVH
`ifndef SYNTHESIS
// implication checked at every rising clock edge out of reset
`define DLG_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dlg assertion failed");
// condition that must never hold out of reset
`define DLG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dlg assertion failed");
`else
`define DLG_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define DLG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- src/dlg_pkg.sv -----
// shared types and constants for the dominant label gate
`timescale 1ns / 1ps
package dlg_pkg;
    localparam int MAX_TREES  = 64;
    localparam int LABEL_BINS = 256;
    localparam int FIFO_DEPTH = 4;

    localparam int TREE_AW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int TREE_CW = $clog2(MAX_TREES + 1);
    localparam int BIN_AW  = (LABEL_BINS > 1) ? $clog2(LABEL_BINS) : 1;
    localparam int BIN_CW  = $clog2(LABEL_BINS + 1);
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int HIST_W  = 21;
    localparam logic [HIST_W-1:0] HIST_MAX = '1;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 144;

    // input op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    // result status codes
    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_FOUND   = 2'd2;

    // register indexes
    localparam logic [7:0] CFG_IGNORED = 8'd0;
    localparam logic [7:0] CFG_RANGE   = 8'd1;

    typedef enum logic [1:0] {K_LOAD, K_PIXEL, K_FRAME} t_kind;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } t_tree;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pixel;
        t_tree       pos;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  ignored_label;
        logic [15:0] max_range;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  dominant_label;
        t_tree       near;
        logic [31:0] dist_squared;
        logic [31:0] marker_number;
    } t_res;
endpackage

// ----- src/dlg_front.sv -----
// front stage: accepts input requests, decodes and filters them
`timescale 1ns / 1ps
module dlg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dlg_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    output logic                          o_push,
    output dlg_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);
    import dlg_pkg::*;

    logic r_vld, n_vld;
    t_cmd r_cmd, n_cmd;
    logic accept, keep, push;

    // decode the request
    always_comb begin
        n_cmd       = r_cmd;
        keep        = 1'b0;
        n_cmd.pixel = s_axis_tdata[7:0];
        unique case (s_axis_tuser)
            OP_LOAD: begin
                keep       = 1'b1;
                n_cmd.kind = K_LOAD;
                n_cmd.pos  = '{x: s_axis_tdata[31:8], y: s_axis_tdata[55:32],
                               z: s_axis_tdata[79:56]};
            end
            OP_PIXEL: begin
                keep       = (9'(s_axis_tdata[7:0]) < 9'(LABEL_BINS));
                n_cmd.kind = K_PIXEL;
            end
            OP_FRAME: begin
                keep       = 1'b1;
                n_cmd.kind = K_FRAME;
                n_cmd.pos  = '{x: s_axis_tdata[103:80], y: s_axis_tdata[127:104],
                               z: 24'd0};
            end
            default: keep = 1'b0;
        endcase
    end

    assign push          = r_vld && !i_full;
    assign s_axis_tready = !r_vld || !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign n_vld         = (r_vld && !push) || (accept && keep);
    assign o_push        = push;
    assign o_cmd         = r_cmd;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept && keep) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// ----- src/dlg_fifo.sv -----
// short command queue between front and back
`timescale 1ns / 1ps
module dlg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dlg_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output dlg_pkg::t_cmd o_data,
    output logic          o_empty
);
    import dlg_pkg::*;

    t_cmd r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ----- src/dlg_back.sv -----
// back stage: histogram, tree table, mode scan and nearest tree search
`timescale 1ns / 1ps
module dlg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  dlg_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  dlg_pkg::t_cfg i_cfg,
    output logic          o_res_vld,
    input  logic          i_res_rdy,
    output dlg_pkg::t_res o_res
);
    import dlg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PIX, S_HIST, S_TREE, S_OUT} t_state;

    logic [HIST_W-1:0] r_hist [LABEL_BINS];
    t_tree             r_tree [MAX_TREES];
    logic [LABEL_BINS-1:0] r_hv;

    t_state r_state;
    logic [TREE_CW-1:0] r_count, r_tidx;
    logic [BIN_CW-1:0]  r_bidx;
    logic [BIN_AW-1:0]  r_paddr, r_rd_idx, r_dom, hist_addr;
    logic [HIST_W-1:0]  r_hrd, r_best_cnt, hist_val;
    logic               r_hvq, r_hrv;
    logic [23:0]        r_vx, r_vy;
    logic [31:0]        r_r2, r_best_d, r_marker;
    logic               r_found;
    t_tree              r_best_pos;
    logic               r_av, r_bv, r_cv;
    t_tree              r_ard, r_bent, r_cent;
    logic signed [24:0] r_bdx, r_bdy;
    logic [48:0]        r_csx, r_csy;
    logic signed [49:0] sqx, sqy;
    logic [49:0]        dsum;
    logic               r_out_vld;
    t_res               r_res;

    logic pop, pix_pop, load_pop, frame_pop, hist_re, hist_we;
    logic h_issue, h_done, t_issue, t_done, hit;

    assign pop       = (r_state == S_IDLE) && i_cmd_vld;
    assign pix_pop   = pop && (i_cmd.kind == K_PIXEL);
    assign load_pop  = pop && (i_cmd.kind == K_LOAD);
    assign frame_pop = pop && (i_cmd.kind == K_FRAME);
    assign o_cmd_pop = pop;

    // histogram port control
    assign h_issue   = (r_state == S_HIST) && (r_bidx < BIN_CW'(LABEL_BINS));
    assign h_done    = (r_state == S_HIST) && !h_issue && !r_hrv;
    assign hist_addr = (r_state == S_IDLE) ? i_cmd.pixel[BIN_AW-1:0] : r_bidx[BIN_AW-1:0];
    assign hist_re   = pix_pop || h_issue;
    assign hist_val  = r_hvq ? r_hrd : '0;
    assign hist_we   = (r_state == S_PIX) && (hist_val < HIST_MAX);

    // tree scan control and distance
    assign t_issue = (r_state == S_TREE) && (r_tidx < r_count);
    assign t_done  = (r_state == S_TREE) && !t_issue && !r_av && !r_bv && !r_cv;
    assign sqx     = r_bdx * r_bdx;
    assign sqy     = r_bdy * r_bdy;
    assign dsum    = {1'b0, r_csx} + {1'b0, r_csy};
    assign hit     = r_cv && (dsum < {18'd0, r_r2}) && (!r_found || dsum[31:0] < r_best_d);

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (hist_re) begin
            r_hrd <= r_hist[hist_addr];
        end
        if (hist_we) begin
            r_hist[r_paddr] <= hist_val + 1'b1;
        end
    end

    // tree table memory
    always_ff @(posedge i_clk) begin
        if (load_pop && (r_count < TREE_CW'(MAX_TREES))) begin
            r_tree[r_count[TREE_AW-1:0]] <= i_cmd.pos;
        end
        if (t_issue) begin
            r_ard <= r_tree[r_tidx[TREE_AW-1:0]];
        end
    end

    // distance pipeline data
    always_ff @(posedge i_clk) begin
        r_bdx  <= $signed({r_ard.x[23], r_ard.x}) - $signed({r_vx[23], r_vx});
        r_bdy  <= $signed({r_ard.y[23], r_ard.y}) - $signed({r_vy[23], r_vy});
        r_bent <= r_ard;
        r_csx  <= sqx[48:0];
        r_csy  <= sqy[48:0];
        r_cent <= r_bent;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_marker  <= '0;
            r_hv      <= '0;
            r_hrv     <= 1'b0;
            r_av      <= 1'b0;
            r_bv      <= 1'b0;
            r_cv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_hrv <= h_issue;
            r_av  <= t_issue;
            r_bv  <= r_av;
            r_cv  <= r_bv;
            if (hist_re) begin
                r_hvq    <= r_hv[hist_addr];
                r_rd_idx <= hist_addr;
            end
            if (hist_we) begin
                r_hv[r_paddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (load_pop && (r_count < TREE_CW'(MAX_TREES))) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (pix_pop) begin
                        r_paddr <= i_cmd.pixel[BIN_AW-1:0];
                        r_state <= S_PIX;
                    end
                    if (frame_pop) begin
                        r_vx       <= i_cmd.pos.x;
                        r_vy       <= i_cmd.pos.y;
                        r_r2       <= 32'(i_cfg.max_range) * 32'(i_cfg.max_range);
                        r_bidx     <= '0;
                        r_best_cnt <= '0;
                        r_dom      <= '0;
                        r_state    <= S_HIST;
                    end
                end
                S_PIX: begin
                    r_state <= S_IDLE;
                end
                S_HIST: begin
                    if (h_issue) begin
                        r_bidx <= r_bidx + 1'b1;
                    end
                    if (r_hrv && (hist_val > r_best_cnt)) begin
                        r_best_cnt <= hist_val;
                        r_dom      <= r_rd_idx;
                    end
                    if (h_done) begin
                        r_hv                 <= '0;
                        r_res                <= '0;
                        r_res.dominant_label <= 8'(r_dom);
                        if (8'(r_dom) == i_cfg.ignored_label) begin
                            r_res.status <= ST_IGNORED;
                            r_out_vld    <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_tidx  <= '0;
                            r_found <= 1'b0;
                            r_state <= S_TREE;
                        end
                    end
                end
                S_TREE: begin
                    if (t_issue) begin
                        r_tidx <= r_tidx + 1'b1;
                    end
                    if (hit) begin
                        r_found    <= 1'b1;
                        r_best_d   <= dsum[31:0];
                        r_best_pos <= r_cent;
                    end
                    if (t_done) begin
                        if (r_found) begin
                            r_res.status        <= ST_FOUND;
                            r_res.near          <= r_best_pos;
                            r_res.dist_squared  <= r_best_d;
                            r_res.marker_number <= r_marker;
                            r_marker            <= r_marker + 1'b1;
                        end else begin
                            r_res.status <= ST_NONE;
                        end
                        r_out_vld <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_rdy) begin
                        r_out_vld <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_vld = r_out_vld;
    assign o_res     = r_res;
endmodule

// ----- src/dominant_label_nearest_point_gate.sv -----
// top level of the dominant label gate with nearest tree search
//
// channel   direction  handshake              payload
// s_axis    in         tvalid / tready        tuser op, tdata point fields
// m_axis    out        tvalid / tready        tuser status, tdata result fields
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// tree load: stored in the back stage while idle; label pixel: histogram
// read while idle, then write in S_PIX through the single ram port
// end of frame: a scan of all LABEL_BINS bins, then, if the label is not ignored,
// all stored trees through the distance pipeline, then one result request
// a front register and a 4 deep queue keep taking requests while the back works
// reset is synchronous, active low; histogram bins clear through valid bits
`timescale 1ns / 1ps
`include "dominant_label_nearest_point_gate_macros.svh"
module dominant_label_nearest_point_gate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pixel[7:0] tree_x[31:8] tree_y[55:32] tree_z[79:56]
    // vehicle_x[103:80] vehicle_y[127:104]
    input  logic [dlg_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dominant_label[7:0] near_x[31:8] near_y[55:32] near_z[79:56]
    // dist_squared[111:80] marker_number[143:112]
    output logic [dlg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import dlg_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, fifo_cmd;
    t_res res;
    logic push, full, pop, empty;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignored_label <= 8'd231;
            r_cfg.max_range     <= 16'd3840;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IGNORED: r_cfg.ignored_label <= i_cfg_data[7:0];
                CFG_RANGE:   r_cfg.max_range     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dlg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_full        (full)
    );

    dlg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (fifo_cmd),
        .o_empty (empty)
    );

    dlg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (!empty),
        .i_cmd     (fifo_cmd),
        .o_cmd_pop (pop),
        .i_cfg     (r_cfg),
        .o_res_vld (m_axis_tvalid),
        .i_res_rdy (m_axis_tready),
        .o_res     (res)
    );

    // result packing
    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {res.marker_number, res.dist_squared, res.near.z,
                           res.near.y, res.near.x, res.dominant_label};

    // checks
    `DLG_ASSERT_IMPLY(a_found_in_range, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_FOUND), m_axis_tdata[111:80] < (32'(r_cfg.max_range) * 32'(r_cfg.max_range)))
    `DLG_ASSERT_IMPLY(a_ignored_label, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_IGNORED), m_axis_tdata[7:0] == r_cfg.ignored_label)
    `DLG_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_FOUND), m_axis_tdata[143:8] == '0)
    `DLG_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, pop && empty)
endmodule
